// ===== rtl/srrip_pkg.sv =====
// Shared types and constants for the SRRIP victim selector.
// Holds the request and result beat layouts and the control state encoding.
// No dependencies.
package srrip_pkg;

  localparam int SET_W = 11;
  localparam int WAY_FIELD_W = 5;

  localparam logic OP_FIND = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic                   operation;
    logic [SET_W-1:0]       set_index;
    logic [WAY_FIELD_W-1:0] way_index;
    logic                   hit;
    logic                   is_writeback;
    logic                   bypass_request;
  } in_item_t;

  typedef struct packed {
    logic [WAY_FIELD_W-1:0] victim_way;
    logic                   victim_valid;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MOD
  } fsm_state_t;

endpackage

// ===== rtl/srrip_row_ram.sv =====
// One-row-per-set storage of the prediction values.
// Single write port, single read port, registered read data. No dependencies.
module srrip_row_ram #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/srrip_row_update.sv =====
// Modify step for one row: age, pick a victim unless bypassed, or set one way.
// Uses the beat types from srrip_pkg.
module srrip_row_update #(
  parameter int NUM_WAYS = 16,
  parameter int RRPV_MAX = 3,
  parameter int VAL_W    = 2,
  parameter int ROW_W    = 32
) (
  input  srrip_pkg::in_item_t  req,
  input  logic [ROW_W-1:0]     row_in,
  output logic [ROW_W-1:0]     row_out,
  output logic                 row_we,
  output srrip_pkg::out_item_t result
);
  import srrip_pkg::*;

  localparam int WAY_W = $clog2(NUM_WAYS);

  logic [VAL_W-1:0]    top;
  logic [VAL_W-1:0]    lift;
  logic [ROW_W-1:0]    row_aged;
  logic [ROW_W-1:0]    row_set;
  logic [WAY_W-1:0]    victim;
  logic                way_ok;
  logic [RRPV_MAX:1]   any_ge;
  logic [NUM_WAYS-1:0] at_top;

  always_comb begin
    any_ge = '0;
    for (int v = 1; v <= RRPV_MAX; v++) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (row_in[w*VAL_W +: VAL_W] >= VAL_W'(v)) begin
          any_ge[v] = 1'b1;
        end
      end
    end
    top = '0;
    for (int v = 1; v <= RRPV_MAX; v++) begin
      if (any_ge[v]) begin
        top = VAL_W'(v);
      end
    end
  end

  assign lift = VAL_W'(RRPV_MAX) - top;

  always_comb begin
    logic [VAL_W:0] sum;
    for (int w = 0; w < NUM_WAYS; w++) begin
      sum = {1'b0, row_in[w*VAL_W +: VAL_W]} + {1'b0, lift};
      if (sum > (VAL_W+1)'(RRPV_MAX)) begin
        row_aged[w*VAL_W +: VAL_W] = VAL_W'(RRPV_MAX);
      end else begin
        row_aged[w*VAL_W +: VAL_W] = sum[VAL_W-1:0];
      end
      at_top[w] = (row_in[w*VAL_W +: VAL_W] >= top);
    end
  end

  always_comb begin
    victim = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (at_top[w]) begin
        victim = WAY_W'(w);
      end
    end
  end

  assign way_ok = ({1'b0, req.way_index} < (WAY_FIELD_W+1)'(NUM_WAYS)) && !req.is_writeback;

  always_comb begin
    row_set = row_in;
    row_set[req.way_index[WAY_W-1:0]*VAL_W +: VAL_W] =
      req.hit ? '0 : VAL_W'(RRPV_MAX - 1);
  end

  always_comb begin
    row_out = row_aged;
    row_we  = 1'b0;
    result  = '0;
    case (req.operation)
      OP_FIND: begin
        row_out             = row_aged;
        row_we              = !req.bypass_request;
        result.victim_valid = 1'b1;
        result.victim_way   = req.bypass_request ? WAY_FIELD_W'(NUM_WAYS)
                                                 : WAY_FIELD_W'(victim);
      end
      OP_UPDATE: begin
        row_out = row_set;
        row_we  = way_ok;
      end
      default: begin
        row_we = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/srrip_victim_select.sv =====
// Top level of the SRRIP victim selector: set reduction, control sequencer,
// row memory and row modify. Depends on srrip_pkg, srrip_row_ram, srrip_row_update.
//
//   beat     direction  payload        handshake
//   in_*     input      in_item_t      in_valid / in_stall
//   out_*    output     out_item_t     out_valid / out_stall
//
// Each request reads its set row (memory read), then modifies it and writes it back
// (modify and write). A new request can be taken during the modify and write of the
// one before, so long as the result slot is free.
// After reset a clearing pass writes every row, with in_stall high.
// A held result keeps the next write back and in_stall high until out_stall drops.
module srrip_victim_select #(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16,
  parameter int RRPV_MAX = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  srrip_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output srrip_pkg::out_item_t out_data
);
  import srrip_pkg::*;

  localparam int VAL_W   = $clog2(RRPV_MAX + 1);
  localparam int ROW_W   = NUM_WAYS * VAL_W;
  localparam int ADDR_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int RECIP_S = 2 * SET_W;
  localparam int PROD_W  = SET_W + RECIP_S;
  localparam longint RECIP = ((64'd1 << RECIP_S) + NUM_SETS - 1) / NUM_SETS;
  localparam bit SET_POW2 = (NUM_SETS & (NUM_SETS - 1)) == 0;
  localparam bit SET_WIDE = NUM_SETS >= (1 << SET_W);

  fsm_state_t state_r, state_nxt;
  in_item_t   req_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [ADDR_W-1:0] set_addr;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              in_accept;
  logic              slot_free;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ROW_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [ROW_W-1:0]  mem_rdata;
  logic              out_load;
  logic [ROW_W-1:0]  upd_row;
  logic              upd_we;
  out_item_t         upd_result;
  logic [ROW_W-1:0]  row_init;

  generate
    if (NUM_SETS == 1) begin : g_one_set
      assign set_addr = '0;
    end else if (SET_WIDE) begin : g_wide_sets
      assign set_addr = ADDR_W'(req_r.set_index);
    end else if (SET_POW2) begin : g_pow2_sets
      assign set_addr = req_r.set_index[ADDR_W-1:0];
    end else begin : g_recip_sets
      logic [PROD_W-1:0]  prod;
      logic [SET_W-1:0]   q_r, q_nxt;
      logic [2*SET_W-1:0] qn;
      logic [SET_W-1:0]   rem;
      assign prod  = PROD_W'(in_data.set_index) * PROD_W'(RECIP);
      assign q_nxt = prod[PROD_W-1:RECIP_S];
      always_ff @(posedge clk) begin
        if (in_accept) begin
          q_r <= q_nxt;
        end
      end
      always_comb begin
        qn  = (2*SET_W)'(q_r) * (2*SET_W)'(NUM_SETS);
        rem = req_r.set_index - qn[SET_W-1:0];
        if (rem >= SET_W'(NUM_SETS)) begin
          rem = rem - SET_W'(NUM_SETS);
        end
      end
      assign set_addr = rem[ADDR_W-1:0];
    end
  endgenerate

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      row_init[w*VAL_W +: VAL_W] = VAL_W'(RRPV_MAX);
    end
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(NUM_SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (slot_free) begin
          state_nxt = in_accept ? ST_READ : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = upd_row;
    mem_re    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = row_init;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_READ: begin
        mem_re = 1'b1;
      end
      ST_MOD: begin
        in_stall = !slot_free;
        mem_we   = slot_free && upd_we;
        out_load = slot_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= in_data;
    end
    if (state_r == ST_READ) begin
      addr_r <= set_addr;
    end
    if (out_load) begin
      out_data_r <= upd_result;
    end
  end

  srrip_row_ram #(
    .DEPTH  (NUM_SETS),
    .ADDR_W (ADDR_W),
    .DATA_W (ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (set_addr),
    .rdata (mem_rdata)
  );

  srrip_row_update #(
    .NUM_WAYS (NUM_WAYS),
    .RRPV_MAX (RRPV_MAX),
    .VAL_W    (VAL_W),
    .ROW_W    (ROW_W)
  ) u_update (
    .req     (req_r),
    .row_in  (mem_rdata),
    .row_out (upd_row),
    .row_we  (upd_we),
    .result  (upd_result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
